// File: rtl/cil_pkg.sv
// Shared package for the compacting indexed list.
// Sizes, operation and status codes, select codes and the control/status structs.
// No dependencies.
`default_nettype none

package cil_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int OP_W        = 2;
  localparam int POS_W       = 6;
  localparam int WORD_W      = 32;
  localparam int STAT_W      = 2;
  localparam int FILL_W      = 7;
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // write port select
  localparam logic [1:0] W_APPEND = 2'd0;
  localparam logic [1:0] W_SET    = 2'd1;
  localparam logic [1:0] W_SHIFT  = 2'd2;

  // read address select
  localparam logic [1:0] R_POS   = 2'd0;
  localparam logic [1:0] R_NEXT  = 2'd1;
  localparam logic [1:0] R_SHIFT = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic [1:0]        wsel;
    logic [1:0]        rsel;
    logic              idx_load;
    logic              idx_inc;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_word;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            oob;
    logic            last;
    logic            shift_end;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/compacting_indexed_list.sv
// Compacting indexed list: a bounded list of signed words held in one RAM.
// Request channel (operation, position, word_in) and response channel
// (status, word_out, fill_count), both valid/stall: a transfer happens at a
// rising edge with valid high and stall low.
// One request is in service at a time. A request is taken only while the
// controller is idle and the response register is empty or being drained.
// Sequencing after a request transfer:
//   append, set, out-of-bounds, full: answered from the execute state
//   get: execute, then a read state for the registered RAM read
//   remove at index p with count n: entries p+1 to n-1 move down in a shift state,
//   one entry per cycle through the RAM's single write port.
// A stalled response holds its value; no new request is taken until that
// response leaves. Reset (synchronous) empties the list and drops any pending
// response; entry contents are not cleared.
// Depends on cil_pkg, cil_ctrl, cil_datapath and cil_ram.
`default_nettype none

module compacting_indexed_list (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [cil_pkg::OP_W-1:0]            operation,
  input  wire logic [cil_pkg::POS_W-1:0]           position,
  input  wire logic signed [cil_pkg::WORD_W-1:0]   word_in,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic      [cil_pkg::STAT_W-1:0]          status,
  output logic signed [cil_pkg::WORD_W-1:0]        word_out,
  output logic      [cil_pkg::FILL_W-1:0]          fill_count
);

  cil_pkg::cmd_t  cmd;
  cil_pkg::stat_t stat;

  cil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cil_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (operation),
    .position  (position),
    .word_in   (word_in),
    .status    (status),
    .word_out  (word_out),
    .fill_count(fill_count)
  );

  a_one_in_service: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in service");

  a_word_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != cil_pkg::ST_OK) |-> (word_out == '0))
    else $error("nonzero word on failed request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == cil_pkg::ST_FULL)
      |-> (fill_count == cil_pkg::FILL_W'(cil_pkg::MAX_ENTRIES)))
    else $error("full reported below capacity");

endmodule

`default_nettype wire

// File: rtl/cil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/cil_datapath.sv
// Datapath: request capture, fill count, shift index, entry RAM and result registers.
// Depends on cil_pkg and cil_ram.
`default_nettype none

module cil_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cil_pkg::cmd_t                 cmd,
  output cil_pkg::stat_t                     stat,
  input  wire logic [cil_pkg::OP_W-1:0]      operation,
  input  wire logic [cil_pkg::POS_W-1:0]     position,
  input  wire logic signed [cil_pkg::WORD_W-1:0] word_in,
  output logic      [cil_pkg::STAT_W-1:0]    status,
  output logic signed [cil_pkg::WORD_W-1:0]  word_out,
  output logic      [cil_pkg::FILL_W-1:0]    fill_count
);

  logic [cil_pkg::OP_W-1:0]   op_q;
  logic [cil_pkg::POS_W-1:0]  pos_q;
  logic [cil_pkg::WORD_W-1:0] word_q;
  logic [cil_pkg::CNT_W-1:0]  count;
  logic [cil_pkg::CNT_W-1:0]  count_next;
  logic [cil_pkg::ADDR_W-1:0] idx;
  logic                       we;
  logic [cil_pkg::ADDR_W-1:0] waddr;
  logic [cil_pkg::WORD_W-1:0] wdata;
  logic [cil_pkg::ADDR_W-1:0] raddr;
  logic [cil_pkg::WORD_W-1:0] rdata;
  logic [cil_pkg::CMP_W-1:0]  pos_w;
  logic [cil_pkg::CMP_W-1:0]  cnt_w;
  logic [cil_pkg::CMP_W-1:0]  idx_w;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      pos_q  <= position;
      word_q <= word_in;
    end
    if (cmd.idx_load) begin
      idx <= cil_pkg::ADDR_W'(pos_q);
    end else if (cmd.idx_inc) begin
      idx <= idx + cil_pkg::ADDR_W'(1);
    end
    if (cmd.out_load) begin
      status     <= cmd.out_status;
      word_out   <= cmd.out_word ? rdata : '0;
      fill_count <= cil_pkg::FILL_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + cil_pkg::CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - cil_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    we = cmd.mem_we;
    case (cmd.wsel)
      cil_pkg::W_APPEND: begin
        waddr = cil_pkg::ADDR_W'(count);
        wdata = word_q;
      end
      cil_pkg::W_SET: begin
        waddr = cil_pkg::ADDR_W'(pos_q);
        wdata = word_q;
      end
      cil_pkg::W_SHIFT: begin
        waddr = idx;
        wdata = rdata;
      end
      default: begin
        waddr = idx;
        wdata = rdata;
        we    = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.rsel)
      cil_pkg::R_POS:   raddr = cil_pkg::ADDR_W'(pos_q);
      cil_pkg::R_NEXT:  raddr = cil_pkg::ADDR_W'(pos_q) + cil_pkg::ADDR_W'(1);
      cil_pkg::R_SHIFT: raddr = idx + cil_pkg::ADDR_W'(2);
      default:          raddr = idx;
    endcase
  end

  cil_ram #(
    .WIDTH(cil_pkg::WORD_W),
    .DEPTH(cil_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pos_w = cil_pkg::CMP_W'(pos_q);
  assign cnt_w = cil_pkg::CMP_W'(count);
  assign idx_w = cil_pkg::CMP_W'(idx);

  always_comb begin
    stat.op        = op_q;
    stat.full      = (count == cil_pkg::CNT_W'(cil_pkg::MAX_ENTRIES));
    stat.oob       = (pos_w >= cnt_w);
    stat.last      = ((pos_w + cil_pkg::CMP_W'(1)) >= cnt_w);
    stat.shift_end = ((idx_w + cil_pkg::CMP_W'(2)) >= cnt_w);
  end

endmodule

`default_nettype wire

// File: rtl/cil_ctrl.sv
// Controller state machine: request handshake, operation sequencing, result valid.
// Depends on cil_pkg.
`default_nettype none

module cil_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  input  wire cil_pkg::stat_t stat,
  output cil_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.wsel       = cil_pkg::W_SET;
    cmd.rsel       = cil_pkg::R_POS;
    cmd.out_status = cil_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (stat.op == cil_pkg::OP_APPEND) begin
          cmd.out_load = 1'b1;
          if (stat.full) begin
            cmd.out_status = cil_pkg::ST_FULL;
          end else begin
            cmd.mem_we  = 1'b1;
            cmd.wsel    = cil_pkg::W_APPEND;
            cmd.cnt_inc = 1'b1;
          end
        end else if (stat.oob) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = cil_pkg::ST_OOB;
        end else begin
          case (stat.op)
            cil_pkg::OP_GET: begin
              cmd.rsel   = cil_pkg::R_POS;
              state_next = S_READ;
            end
            cil_pkg::OP_SET: begin
              cmd.mem_we   = 1'b1;
              cmd.wsel     = cil_pkg::W_SET;
              cmd.out_load = 1'b1;
            end
            default: begin
              if (stat.last) begin
                cmd.cnt_dec  = 1'b1;
                cmd.out_load = 1'b1;
              end else begin
                cmd.idx_load = 1'b1;
                cmd.rsel     = cil_pkg::R_NEXT;
                state_next   = S_SHIFT;
              end
            end
          endcase
        end
      end
      S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_word = 1'b1;
        state_next   = S_IDLE;
      end
      S_SHIFT: begin
        // write entry idx from idx+1, prefetch idx+2
        cmd.mem_we = 1'b1;
        cmd.wsel   = cil_pkg::W_SHIFT;
        cmd.rsel   = cil_pkg::R_SHIFT;
        if (stat.shift_end) begin
          cmd.cnt_dec  = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/sv/compacting_indexed_list_tb.sv
// Testbench for compacting_indexed_list: directed and random list requests checked
// against a scoreboard that predicts status, read word and fill count per request.
// Depends on cil_pkg and the compacting_indexed_list RTL.
`timescale 1ns / 100ps

module compacting_indexed_list_tb;
  import cil_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_ITEMS = 1325;
  localparam int BLOCKS       = 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] word;
    logic [FILL_W-1:0] fill;
  } list_result_t;

  class list_scoreboard;
    logic [WORD_W-1:0] entries [MAX_ENTRIES];
    int unsigned       count = 0;
    list_result_t      expected_results [$];
    int                errors = 0;

    function int pending();
      return expected_results.size();
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [WORD_W-1:0] word);
      list_result_t r;
      r.status = ST_OK;
      r.word   = '0;
      if (op == OP_APPEND) begin
        if (count >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          entries[count] = word;
          count++;
        end
      end else if (pos >= count) begin
        r.status = ST_OOB;
      end else if (op == OP_GET) begin
        r.word = entries[pos];
      end else if (op == OP_SET) begin
        entries[pos] = word;
      end else begin
        for (int unsigned i = pos; i + 1 < count; i++)
          entries[i] = entries[i + 1];
        count--;
      end
      r.fill = FILL_W'(count);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] word,
                               logic [FILL_W-1:0] fill);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d word %h fill %0d", st, word, fill);
        return;
      end
      exp = expected_results.pop_front();
      if (st !== exp.status || word !== exp.word || fill !== exp.fill) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d word %h fill %0d, got status %0d word %h fill %0d",
                   exp.status, exp.word, exp.fill, st, word, fill);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     req_valid;
  logic                     req_stall;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word_in;
  logic                     rsp_valid;
  logic                     rsp_stall;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] word_out;
  logic [FILL_W-1:0]        fill_count;

  int send_idle_pct;
  int rcv_stall_pct;

  list_scoreboard sb = new;

  compacting_indexed_list u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .position   (position),
    .word_in    (word_in),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .word_out   (word_out),
    .fill_count (fill_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // inputs change only at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    if (!rst && req_valid && !req_stall)
      sb.apply_request(operation, position, word_in);
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_result(status, word_out, fill_count);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("compacting_indexed_list_tb NOT OK");
    $finish;
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] word);
    logic fire;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    position  <= pos;
    word_in   <= word;
    do begin
      @(negedge clk);
      fire = req_valid && !req_stall;
      @(posedge clk);
    end while (!fire);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic             grow;
    int               r;
    int               rp;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;

    rst           = 1'b1;
    req_valid     = 1'b0;
    operation     = '0;
    position      = '0;
    word_in       = '0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    grow          = 1'b1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty list: every indexed request is out of bounds
    send_req(OP_GET,    6'd0,  32'h1234_5678);
    send_req(OP_REMOVE, 6'd0,  32'h0);
    send_req(OP_SET,    6'd0,  32'hdead_beef);
    send_req(OP_APPEND, 6'd63, 32'h7fff_ffff);
    send_req(OP_APPEND, 6'd0,  32'h8000_0000);
    send_req(OP_APPEND, 6'd42, 32'h0000_0000);
    send_req(OP_APPEND, 6'd21, 32'hffff_ffff);
    send_req(OP_APPEND, 6'd5,  32'h5a5a_5a5a);
    for (int i = 0; i < 5; i++)
      send_req(OP_GET, POS_W'(i), 32'hffff_ffff);
    send_req(OP_GET,    6'd5,  32'h0);
    send_req(OP_GET,    6'd63, 32'h0);
    send_req(OP_SET,    6'd2,  32'ha5a5_a5a5);
    send_req(OP_GET,    6'd2,  32'h0);
    send_req(OP_REMOVE, 6'd4,  32'h0);
    send_req(OP_REMOVE, 6'd0,  32'hffff_ffff);
    send_req(OP_GET,    6'd0,  32'h0);
    send_req(OP_GET,    6'd2,  32'h0);
    send_req(OP_REMOVE, 6'd1,  32'h0);
    send_req(OP_GET,    6'd1,  32'h0);
    send_req(OP_REMOVE, 6'd2,  32'h0);
    drain_results();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk % 4)
        0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rcv_stall_pct = 68; end
        default: begin send_idle_pct = 17; rcv_stall_pct = 17; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / BLOCKS; n++) begin
        // sweep the fill level between empty and full, lingering at full
        if (sb.count == 0)
          grow = 1'b1;
        else if (sb.count == MAX_ENTRIES && $urandom_range(0, 7) == 0)
          grow = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 55)
          op = grow ? OP_APPEND : OP_REMOVE;
        else if (r < 70)
          op = grow ? OP_REMOVE : OP_APPEND;
        else if (r < 85)
          op = OP_GET;
        else
          op = OP_SET;
        rp = $urandom_range(0, 99);
        if (rp < 8)
          pos = POS_W'($urandom_range(0, 63));
        else if (rp < 14)
          pos = POS_W'(sb.count);
        else if (sb.count > 0)
          pos = POS_W'($urandom_range(0, sb.count - 1));
        else
          pos = '0;
        send_req(op, pos, pick_word());
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("compacting_indexed_list_tb OK");
    end else begin
      $display("compacting_indexed_list_tb NOT OK");
    end
    $finish;
  end

endmodule
